[sv/swsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsf_pkg
// shared types, constants and helpers of the spir-v word stream framer
// ----------------------------------------------------------------------------
package swsf_pkg;

   localparam logic [31:0] MagicNative  = 32'h0723_0203;
   localparam logic [31:0] MagicSwapped = 32'h0302_2307;
   // header_pos value once the five header words are through
   localparam logic [2:0]  HeaderWords  = 3'd5;
   localparam logic [2:0]  LastHeaderSlot = 3'd4;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_MAGIC = 3'd1,
      STATUS_SHORT     = 3'd2,
      STATUS_TRUNC     = 3'd3,
      STATUS_ZERO      = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  header_pos;
      logic        swap_bytes;
      logic [15:0] cur_opcode;
      logic [15:0] cur_count;
      logic [15:0] words_left;
      logic [15:0] word_pos;
      status_type  fault_code;
   } frame_state_type;

   typedef struct packed {
      logic [31:0] word_out;
      logic        is_header;
      logic [2:0]  header_slot;
      logic [15:0] opcode;
      logic [15:0] word_count;
      logic [15:0] word_index;
      logic        instr_last;
      status_type  status;
   } frame_result_type;

   localparam frame_state_type StateReset = '{
      header_pos: 3'd0,
      swap_bytes: 1'b0,
      cur_opcode: 16'd0,
      cur_count:  16'd0,
      words_left: 16'd0,
      word_pos:   16'd0,
      fault_code: STATUS_OK
   };

   function automatic logic [31:0] byte_swap(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

[sv/swsf_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsf_step
// next-state and result logic for one module word
// ----------------------------------------------------------------------------
module swsf_step (
   input  swsf_pkg::frame_state_type  state_cur,
   input  logic [31:0]                word_in,
   input  logic                       module_end,
   output swsf_pkg::frame_state_type  state_nxt,
   output swsf_pkg::frame_result_type result
);
   import swsf_pkg::*;

   logic [31:0] conv_word;
   logic        hdr_swap;
   logic [15:0] body_opcode;
   logic [15:0] body_count;
   logic [15:0] new_left;
   logic [15:0] new_pos;
   status_type  hdr_status;

   always_comb begin
      state_nxt   = state_cur;
      result      = '0;
      result.status = STATUS_OK;
      hdr_swap    = state_cur.swap_bytes;
      hdr_status  = STATUS_OK;
      conv_word   = state_cur.swap_bytes ? byte_swap(word_in) : word_in;
      body_opcode = conv_word[15:0];
      body_count  = conv_word[31:16];
      new_left    = state_cur.words_left - 16'd1;
      new_pos     = state_cur.word_pos + 16'd1;

      priority if (state_cur.fault_code != STATUS_OK) begin
         // draining after an error
         result.status = state_cur.fault_code;
         if (module_end) begin
            state_nxt = StateReset;
         end
      end else if (state_cur.header_pos < HeaderWords) begin
         if (state_cur.header_pos == 3'd0) begin
            priority if (word_in == MagicNative) begin
               hdr_swap = 1'b0;
            end else if (word_in == MagicSwapped) begin
               hdr_swap = 1'b1;
            end else begin
               hdr_status = STATUS_BAD_MAGIC;
            end
         end
         if (hdr_status == STATUS_OK && module_end
             && state_cur.header_pos < LastHeaderSlot) begin
            hdr_status = STATUS_SHORT;
         end
         result.word_out    = (hdr_status != STATUS_BAD_MAGIC && hdr_swap)
                              ? byte_swap(word_in) : word_in;
         result.is_header   = 1'b1;
         result.header_slot = state_cur.header_pos;
         result.status      = hdr_status;
         state_nxt.swap_bytes = hdr_swap;
         priority if (module_end) begin
            state_nxt = StateReset;
         end else if (hdr_status != STATUS_OK) begin
            state_nxt.fault_code = hdr_status;
         end else begin
            state_nxt.header_pos = state_cur.header_pos + 3'd1;
         end
      end else begin
         result.word_out = conv_word;
         priority if (state_cur.words_left == 16'd0 && body_count == 16'd0) begin
            // zero word count cannot make progress
            result.opcode     = body_opcode;
            result.instr_last = 1'b1;
            result.status     = STATUS_ZERO;
            if (module_end) begin
               state_nxt = StateReset;
            end else begin
               state_nxt.fault_code = STATUS_ZERO;
            end
         end else begin
            if (state_cur.words_left == 16'd0) begin
               state_nxt.cur_opcode = body_opcode;
               state_nxt.cur_count  = body_count;
               state_nxt.word_pos   = 16'd0;
               state_nxt.words_left = body_count - 16'd1;
            end else begin
               state_nxt.word_pos   = new_pos;
               state_nxt.words_left = new_left;
            end
            result.opcode     = state_nxt.cur_opcode;
            result.word_count = state_nxt.cur_count;
            result.word_index = state_nxt.word_pos;
            result.instr_last = (state_nxt.words_left == 16'd0);
            result.status     = (module_end && state_nxt.words_left != 16'd0)
                                ? STATUS_TRUNC : STATUS_OK;
            if (module_end) begin
               state_nxt = StateReset;
            end
         end
      end
   end

endmodule

[sv/spirv_word_stream_framer.sv]
`timescale 1ns / 1ps
// an accepted word's result is registered and shows on the rsp_ channel in the cycle after acceptance
// throughput: one word per cycle, sustained while rsp_ready stays high
// the framing state and the result register are the only storage; the step
//   logic between them is a byte swap, a few compares and a 16-bit decrement
// reset clears the framing state and empties the result register, so the
//   next word is taken as a magic number
// ----------------------------------------------------------------------------
// spirv_word_stream_framer
// splits a spir-v module word stream into header words and instructions,
// with byte-order conversion and error reporting
// ----------------------------------------------------------------------------
module spirv_word_stream_framer (
   input  logic        clock,
   input  logic        reset,
   // word input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_word_in,
   input  logic        req_module_end,
   // tagged word output channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_word_out,
   output logic        rsp_is_header,
   output logic [2:0]  rsp_header_slot,
   output logic [15:0] rsp_opcode,
   output logic [15:0] rsp_word_count,
   output logic [15:0] rsp_word_index,
   output logic        rsp_instr_last,
   output logic [2:0]  rsp_status
);
   import swsf_pkg::*;

   frame_state_type  state_ff, state_in, state_step;
   frame_result_type result_ff, result_step;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_take;

   // a new transaction may enter whenever the result register is free or
   // its current contents leave in the same cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   swsf_step u_step (
      .state_cur  (state_ff),
      .word_in    (req_word_in),
      .module_end (req_module_end),
      .state_nxt  (state_step),
      .result     (result_step)
   );

   // state only moves on an accepted transaction
   assign state_in = req_take ? state_step : state_ff;

   always_comb begin
      priority if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on acceptance only
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_step;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_out    = result_ff.word_out;
   assign rsp_is_header   = result_ff.is_header;
   assign rsp_header_slot = result_ff.header_slot;
   assign rsp_opcode      = result_ff.opcode;
   assign rsp_word_count  = result_ff.word_count;
   assign rsp_word_index  = result_ff.word_index;
   assign rsp_instr_last  = result_ff.instr_last;
   assign rsp_status      = result_ff.status;

   // header_pos never runs past the body marker
   a_header_pos_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.header_pos <= HeaderWords)
      else $error("header position beyond body marker");

   // an instruction can only be open once the header is through
   a_body_only : assert property (@(posedge clock) disable iff (reset)
      state_ff.words_left != 16'd0 |-> state_ff.header_pos == HeaderWords)
      else $error("instruction open while still in header");

   // a module end always returns the framer to its reset state
   a_end_resets : assert property (@(posedge clock) disable iff (reset)
      req_take && req_module_end |=>
         state_ff.header_pos == 3'd0 && state_ff.fault_code == STATUS_OK
         && state_ff.words_left == 16'd0 && !state_ff.swap_bytes)
      else $error("state not cleared after module end");

   // header words carry no instruction tags
   a_header_tags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |->
         rsp_opcode == 16'd0 && rsp_word_count == 16'd0 && !rsp_instr_last)
      else $error("instruction tags on a header word");

   // a good last word sits at the final index of its instruction
   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_instr_last && rsp_status == STATUS_OK |->
         ({1'b0, rsp_word_index} + 17'd1) == {1'b0, rsp_word_count})
      else $error("last word flag at wrong index");

endmodule

[verif/spirv_word_stream_framer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spirv_word_stream_framer_tb
// self-checking bench for the spir-v word stream framer: queued module words
// (clean modules in both byte orders, broken headers, cut and zero-length
// instructions, noise) go in over the req_ channel, every tagged word on the
// rsp_ channel is checked field by field against a local framing predictor
// ----------------------------------------------------------------------------
module spirv_word_stream_framer_tb;
   import swsf_pkg::*;

   // shapes of generated modules
   typedef enum int {
      SHAPE_CLEAN,
      SHAPE_TRUNC,
      SHAPE_ZERO,
      SHAPE_SHORT,
      SHAPE_BAD_MAGIC,
      SHAPE_HEADER_ONLY,
      SHAPE_NOISE
   } module_shape_type;

   // one raw word as stored, with its end-of-module mark
   typedef struct packed {
      logic [31:0] raw;
      logic        ends_module;
   } stream_word_type;

   localparam int RandomWords  = 1150;
   localparam int QuietFrom    = 500;
   localparam int QuietTo      = 750;
   localparam int HoldAfter    = 200;
   localparam int HoldCycles   = 60;
   localparam int ReportLimit  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_word_in = '0;
   logic        req_module_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_word_out;
   logic        rsp_is_header;
   logic [2:0]  rsp_header_slot;
   logic [15:0] rsp_opcode;
   logic [15:0] rsp_word_count;
   logic [15:0] rsp_word_index;
   logic        rsp_instr_last;
   logic [2:0]  rsp_status;

   stream_word_type  words_to_send[$];
   frame_result_type tagged_words_due[$];
   int words_sent     = 0;
   int total_words    = 0;
   int mismatch_count = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   // predictor framing state
   logic [2:0]  hdr_count     = '0;
   logic        swapped_order = 1'b0;
   logic [15:0] instr_opcode  = '0;
   logic [15:0] instr_count   = '0;
   logic [15:0] remaining     = '0;
   logic [15:0] index_pos     = '0;
   status_type  drain_status  = STATUS_OK;

   spirv_word_stream_framer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word_in     (req_word_in),
      .req_module_end  (req_module_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word_out    (rsp_word_out),
      .rsp_is_header   (rsp_is_header),
      .rsp_header_slot (rsp_header_slot),
      .rsp_opcode      (rsp_opcode),
      .rsp_word_count  (rsp_word_count),
      .rsp_word_index  (rsp_word_index),
      .rsp_instr_last  (rsp_instr_last),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // reverse the four bytes of a word
   function automatic logic [31:0] swap_order(input logic [31:0] w);
      return ((w & 32'h0000_00FF) << 24) | ((w & 32'h0000_FF00) << 8) |
             ((w & 32'h00FF_0000) >> 8) | ((w & 32'hFF00_0000) >> 24);
   endfunction

   // back to the start of a module, next word is a magic number
   function automatic void clear_framing();
      hdr_count     = '0;
      swapped_order = 1'b0;
      instr_opcode  = '0;
      instr_count   = '0;
      remaining     = '0;
      index_pos     = '0;
      drain_status  = STATUS_OK;
   endfunction

   // tag one accepted word and advance the framing state
   function automatic frame_result_type frame_word(input logic [31:0] raw,
                                                   input logic ends_module);
      frame_result_type r;
      logic [31:0]      w;
      status_type       st;
      r = '0;
      // draining after an error: only the error code comes out
      if (drain_status != STATUS_OK) begin
         r.status = drain_status;
         if (ends_module) clear_framing();
         return r;
      end
      // header words, the magic number picks the byte order
      if (hdr_count < HeaderWords) begin
         st = STATUS_OK;
         if (hdr_count == 3'd0) begin
            if (raw == MagicNative) begin
               swapped_order = 1'b0;
            end else if (raw == MagicSwapped) begin
               swapped_order = 1'b1;
            end else begin
               st = STATUS_BAD_MAGIC;
            end
         end
         w = (st == STATUS_OK && swapped_order) ? swap_order(raw) : raw;
         // module ending before the reserved slot is too short
         if (st == STATUS_OK && ends_module && hdr_count < LastHeaderSlot) begin
            st = STATUS_SHORT;
         end
         r.word_out    = w;
         r.is_header   = 1'b1;
         r.header_slot = hdr_count;
         r.status      = st;
         if (ends_module) begin
            clear_framing();
         end else if (st != STATUS_OK) begin
            drain_status = st;
         end else begin
            hdr_count = hdr_count + 3'd1;
         end
         return r;
      end
      // body words
      w = swapped_order ? swap_order(raw) : raw;
      r.word_out = w;
      if (remaining == 16'd0) begin
         // zero word count would never advance, flagged as an error
         if (w[31:16] == 16'd0) begin
            r.opcode     = w[15:0];
            r.instr_last = 1'b1;
            r.status     = STATUS_ZERO;
            if (ends_module) begin
               clear_framing();
            end else begin
               drain_status = STATUS_ZERO;
            end
            return r;
         end
         instr_opcode = w[15:0];
         instr_count  = w[31:16];
         index_pos    = '0;
         remaining    = w[31:16] - 16'd1;
      end else begin
         index_pos = index_pos + 16'd1;
         remaining = remaining - 16'd1;
      end
      r.opcode     = instr_opcode;
      r.word_count = instr_count;
      r.word_index = index_pos;
      r.instr_last = (remaining == 16'd0);
      r.status     = (ends_module && remaining != 16'd0) ? STATUS_TRUNC : STATUS_OK;
      if (ends_module) clear_framing();
      return r;
   endfunction

   // queue one logical word, stored byte-swapped for swapped modules
   task automatic put_word(input logic [31:0] logical, input bit swapped,
                           input bit ends_module);
      stream_word_type item;
      item.raw         = swapped ? swap_order(logical) : logical;
      item.ends_module = ends_module;
      words_to_send = {words_to_send, item};
   endtask

   // magic number plus the next header slots, random contents
   task automatic put_header(input bit swapped, input int n_words, input bit ends_last);
      put_word(MagicNative, swapped, ends_last && n_words == 1);
      for (int i = 1; i < n_words; i++) begin
         put_word($urandom, swapped, ends_last && i == n_words - 1);
      end
   endtask

   // instruction of the given count, of which only n_emit words are sent
   task automatic put_instr(input bit swapped, input logic [15:0] count,
                            input int n_emit, input bit ends_last);
      put_word({count, 16'($urandom)}, swapped, ends_last && n_emit == 1);
      for (int i = 1; i < n_emit; i++) begin
         put_word($urandom, swapped, ends_last && i == n_emit - 1);
      end
   endtask

   // mostly short instructions, now and then a longer one
   function automatic int pick_count();
      if ($urandom_range(0, 19) == 0) return $urandom_range(7, 40);
      return $urandom_range(1, 6);
   endfunction

   task automatic put_module(input module_shape_type shape);
      bit          swapped;
      int          n_instr;
      int          cnt;
      int          n_drain;
      logic [31:0] raw;
      swapped = 1'($urandom_range(0, 1));
      case (shape)
         SHAPE_CLEAN: begin
            put_header(swapped, 5, 1'b0);
            n_instr = $urandom_range(1, 8);
            for (int i = 0; i < n_instr; i++) begin
               cnt = pick_count();
               put_instr(swapped, 16'(cnt), cnt, i == n_instr - 1);
            end
         end
         SHAPE_TRUNC: begin
            put_header(swapped, 5, 1'b0);
            n_instr = $urandom_range(0, 3);
            for (int i = 0; i < n_instr; i++) begin
               cnt = pick_count();
               put_instr(swapped, 16'(cnt), cnt, 1'b0);
            end
            // sometimes a huge count, cut after a few words
            cnt = $urandom_range(0, 1) ? $urandom_range(2, 8) : $urandom_range(2, 65535);
            put_instr(swapped, 16'(cnt), $urandom_range(1, (cnt > 7) ? 6 : cnt - 1), 1'b1);
         end
         SHAPE_ZERO: begin
            put_header(swapped, 5, 1'b0);
            n_instr = $urandom_range(0, 3);
            for (int i = 0; i < n_instr; i++) begin
               cnt = pick_count();
               put_instr(swapped, 16'(cnt), cnt, 1'b0);
            end
            n_drain = $urandom_range(0, 3);
            put_word({16'h0000, 16'($urandom)}, swapped, n_drain == 0);
            for (int i = 0; i < n_drain; i++) put_word($urandom, 1'b0, i == n_drain - 1);
         end
         SHAPE_SHORT: begin
            put_header(swapped, $urandom_range(1, 4), 1'b1);
         end
         SHAPE_BAD_MAGIC: begin
            raw = $urandom;
            if (raw == MagicNative || raw == MagicSwapped) raw = ~raw;
            n_drain = $urandom_range(0, 4);
            put_word(raw, 1'b0, n_drain == 0);
            for (int i = 0; i < n_drain; i++) put_word($urandom, 1'b0, i == n_drain - 1);
         end
         SHAPE_HEADER_ONLY: begin
            put_header(swapped, 5, 1'b1);
         end
         default: begin
            // unframed junk, the final word ends it so the next module starts clean
            n_drain = $urandom_range(1, 8);
            for (int i = 0; i < n_drain; i++) begin
               put_word($urandom, 1'b0, i == n_drain - 1 || $urandom_range(0, 3) == 0);
            end
         end
      endcase
   endtask

   // no idling in the quiet window or while the receiver holds off
   function automatic bit sender_idles();
      if ((words_sent >= QuietFrom && words_sent < QuietTo) || hold_left > 0) return 1'b0;
      return $urandom_range(0, 99) < 28;
   endfunction

   // word driver: keeps valid and payload steady until the transaction completes
   always @(posedge clock) begin : word_driver
      bit               present;
      stream_word_type  nxt;
      frame_result_type expected_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         present = req_valid;
         if (req_valid && req_ready) begin
            expected_word    = frame_word(req_word_in, req_module_end);
            tagged_words_due = {tagged_words_due, expected_word};
            words_sent++;
            present = 1'b0;
         end
         if (!present && words_to_send.size() > 0 && !sender_idles()) begin
            nxt = words_to_send.pop_front();
            req_word_in    <= nxt.raw;
            req_module_end <= nxt.ends_module;
            present = 1'b1;
         end
         req_valid <= present;
      end
   end

   // result receiver: random stalls, one long hold-off to back up the framer
   always @(posedge clock) begin : result_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_sent >= HoldAfter) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (words_sent >= QuietFrom && words_sent < QuietTo) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= 28;
      end
   end

   // result monitor: each transaction against the oldest expected tagged word
   always @(posedge clock) begin : result_monitor
      frame_result_type due;
      bit               differs;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tagged_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
               $display("%0t: unexpected result word %h status %0d",
                        $realtime, rsp_word_out, rsp_status);
            end
         end else begin
            due = tagged_words_due.pop_front();
            differs = rsp_word_out    !== due.word_out    ||
                      rsp_is_header   !== due.is_header   ||
                      rsp_header_slot !== due.header_slot ||
                      rsp_opcode      !== due.opcode      ||
                      rsp_word_count  !== due.word_count  ||
                      rsp_word_index  !== due.word_index  ||
                      rsp_instr_last  !== due.instr_last  ||
                      rsp_status      !== due.status;
            if (differs) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("%0t: expected w %h h %b s %0d op %h cnt %h idx %h l %b st %0d",
                           $realtime, due.word_out, due.is_header, due.header_slot,
                           due.opcode, due.word_count, due.word_index, due.instr_last,
                           due.status);
                  $display("%0t:      got w %h h %b s %0d op %h cnt %h idx %h l %b st %0d",
                           $realtime, rsp_word_out, rsp_is_header, rsp_header_slot,
                           rsp_opcode, rsp_word_count, rsp_word_index, rsp_instr_last,
                           rsp_status);
               end
            end
         end
      end
   end

   initial begin
      int          directed_words;
      int          pick;
      // native module: extreme header words, a one-word instruction with
      // opcode ffff, a two-word one, then a zero count drained to the end
      put_word(MagicNative, 1'b0, 1'b0);
      put_word(32'h0001_0600, 1'b0, 1'b0);
      put_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      put_word(32'h0000_0000, 1'b0, 1'b0);
      put_word(32'h0000_0000, 1'b0, 1'b0);
      put_word({16'd1, 16'hFFFF}, 1'b0, 1'b0);
      put_word({16'd2, 16'h0000}, 1'b0, 1'b0);
      put_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      put_word({16'd0, 16'h1234}, 1'b0, 1'b0);
      put_word(32'hA5A5_5A5A, 1'b0, 1'b1);
      // byte-swapped module, maximum word count cut short by the end
      put_word(MagicNative, 1'b1, 1'b0);
      put_word(32'h0001_0500, 1'b1, 1'b0);
      put_word($urandom, 1'b1, 1'b0);
      put_word($urandom, 1'b1, 1'b0);
      put_word($urandom, 1'b1, 1'b0);
      put_word({16'hFFFF, 16'h0011}, 1'b1, 1'b0);
      put_word(32'h0123_4567, 1'b1, 1'b1);
      // bad magic then one drained word
      put_word(32'h0000_0000, 1'b0, 1'b0);
      put_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      // module ending on the version word
      put_word(MagicNative, 1'b0, 1'b0);
      put_word(32'h0001_0000, 1'b0, 1'b1);
      // header with nothing after it is a valid module
      put_header(1'b1, 5, 1'b1);
      directed_words = words_to_send.size();

      // random part: mostly well-formed modules, the rest broken or junk
      while (words_to_send.size() < directed_words + RandomWords) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)      put_module(SHAPE_CLEAN);
         else if (pick < 70) put_module(SHAPE_ZERO);
         else if (pick < 78) put_module(SHAPE_TRUNC);
         else if (pick < 85) put_module(SHAPE_SHORT);
         else if (pick < 91) put_module(SHAPE_BAD_MAGIC);
         else if (pick < 95) put_module(SHAPE_HEADER_ONLY);
         else                put_module(SHAPE_NOISE);
      end
      total_words = words_to_send.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all words accepted, then all tagged words back, then a short quiet spell
      while (words_sent < total_words) @(posedge clock);
      while (tagged_words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && tagged_words_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
